/* hw/rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Operation codes, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default store geometry.
  localparam int unsigned DefDepth     = 64;
  localparam int unsigned DefDataWidth = 32;

  // Fixed field widths of the word interfaces.
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned KindWidth    = 3;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned DefCountWidth = $clog2(DefDepth + 1);

  // Operation requested by an input word.
  typedef enum logic [KindWidth-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REVERSE    = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_e;

  // Completion status reported with each result word.
  typedef enum logic [StatusWidth-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

endpackage

/* hw/rtl/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_if: channel interfaces of the double-ended queue
// One interface for operation words and one for result words, each with
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::KindWidth-1:0] kind;
  logic [deq_pkg::WordWidth-1:0] data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface deq_out_if #(
  parameter int unsigned CountWidth = deq_pkg::DefCountWidth
);
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::WordWidth-1:0]  front_value;
  logic [deq_pkg::WordWidth-1:0]  back_value;
  logic [CountWidth-1:0]          element_count;
  logic                           is_empty;
  logic [deq_pkg::StatusWidth-1:0] status;

  modport source (output valid, output front_value, output back_value,
                  output element_count, output is_empty, output status,
                  input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input element_count, input is_empty, input status,
                  output ready);
endinterface

/* hw/rtl/double_ended_queue_top.sv */
// Each operation passes the states IDLE (accept and store write), READ (both ends read
// through the single store memory with its registered read) and RESP (result load);
// a new operation is accepted only once the last one has loaded its result.
// The next operation is accepted while a result still waits to be taken.
// Reset clears the head, the count and the direction flag; the store itself
// holds no defined contents until written.
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue
// Ring buffer in one synchronous memory with a head pointer, a count and a
// direction flag that lets reverse finish without moving any data.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned DEPTH      = deq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);
  import deq_pkg::*;

  localparam int unsigned AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = CountW + 1;

  // Physical slot that lies k steps after base, with k at most DEPTH.
  function automatic logic [AddrW-1:0] ring_add(logic [AddrW-1:0] base,
                                                logic [CountW-1:0] k);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(k);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[AddrW-1:0];
  endfunction

  // Control state.
  state_e            state_q, state_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic              rev_q, rev_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;

  // Controller outputs.
  logic in_ready;
  logic rd_en;
  logic out_load;

  // Store and its read ports.
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_head_q, rd_tail_q;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AddrW-1:0]      tail_addr;

  // Result payload registers.
  logic [DATA_WIDTH-1:0] front_q, back_q;
  logic [CountW-1:0]     res_count_q;
  logic                  res_empty_q;
  status_e               res_status_q;

  // Input word resized to the stored width.
  logic [WordWidth+DATA_WIDTH-1:0] data_ext;
  logic [DATA_WIDTH-1:0]           data_word;
  logic                            accept;
  logic                            full;
  logic                            empty;
  kind_e                           kind;

  assign data_ext  = {{DATA_WIDTH{1'b0}}, in_i.data_in};
  assign data_word = data_ext[DATA_WIDTH-1:0];
  assign accept    = in_i.valid & in_ready;
  assign full      = (count_q == CountW'(DEPTH));
  assign empty     = (count_q == '0);
  assign kind      = kind_e'(in_i.kind);

  // Next state of the controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_READ: rd_en    = 1'b1;
      ST_RESP: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // Pointer update and slot write for an accepted operation.
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = ring_add(head_q, count_q);
    wr_data  = data_word;
    if (accept) begin
      status_d = STATUS_DONE;
      unique case (kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CountW'(1);
            // Front push in normal order, or back push when reversed,
            // lands before the physical head.
            if ((kind == KIND_PUSH_FRONT) != rev_q) begin
              head_d  = (head_q == '0) ? AddrW'(DEPTH - 1) : head_q - AddrW'(1);
              wr_addr = head_d;
            end
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            count_d = count_q - CountW'(1);
            if ((kind == KIND_POP_FRONT) != rev_q) begin
              head_d = (head_q == AddrW'(DEPTH - 1)) ? '0 : head_q + AddrW'(1);
            end
          end
        end
        KIND_REVERSE: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            rev_d = !rev_q;
          end
        end
        KIND_CLEAR: begin
          head_d  = '0;
          count_d = '0;
          rev_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Physical slot of the last stored word.
  assign tail_addr = empty ? head_q : ring_add(head_q, count_q - CountW'(1));

  // Store write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Store read ports, both ends at once; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_head_q <= mem_q[head_q];
      rd_tail_q <= mem_q[tail_addr];
    end
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      status_q    <= STATUS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; the ends swap roles when the order is reversed.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (empty) begin
        front_q <= '0;
        back_q  <= '0;
      end else begin
        front_q <= rev_q ? rd_tail_q : rd_head_q;
        back_q  <= rev_q ? rd_head_q : rd_tail_q;
      end
      res_count_q  <= count_q;
      res_empty_q  <= empty;
      res_status_q <= status_q;
    end
  end

  // Port drive.
  logic [WordWidth+DATA_WIDTH-1:0] front_ext, back_ext;
  assign front_ext = {{WordWidth{1'b0}}, front_q};
  assign back_ext  = {{WordWidth{1'b0}}, back_q};

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.front_value   = front_ext[WordWidth-1:0];
  assign out_o.back_value    = back_ext[WordWidth-1:0];
  assign out_o.element_count = res_count_q;
  assign out_o.is_empty      = res_empty_q;
  assign out_o.status        = res_status_q;

endmodule

/* hw/rtl/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the result channel, checks that a stalled result word stays offered and that the reported fields agree.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int unsigned DEPTH = deq_pkg::DefDepth
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [deq_pkg::WordWidth-1:0]       front_value_i,
  input logic [deq_pkg::WordWidth-1:0]       back_value_i,
  input logic [$clog2(DEPTH + 1)-1:0]        element_count_i,
  input logic                                is_empty_i,
  input logic [deq_pkg::StatusWidth-1:0]     status_i
);
  import deq_pkg::*;

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  // A result word stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // The empty flag agrees with the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_empty_i == (element_count_i == '0)))
    else $error("empty flag disagrees with count");

  // An empty queue reports zero at both ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_empty_i |-> (front_value_i == '0) && (back_value_i == '0))
    else $error("empty queue reports nonzero end values");

  // The count never exceeds the capacity and the status is a known code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (element_count_i <= CountW'(DEPTH)) &&
                    (status_i == STATUS_DONE || status_i == STATUS_FULL ||
                     status_i == STATUS_EMPTY))
    else $error("count over capacity or unknown status");

endmodule

bind double_ended_queue_top deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .front_value_i   (out_o.front_value),
  .back_value_i    (out_o.back_value),
  .element_count_i (out_o.element_count),
  .is_empty_i      (out_o.is_empty),
  .status_i        (out_o.status)
);
